// ===== design/i2cmbw_pkg.sv =====
`default_nettype none

package i2cmbw_pkg;

    // Register map, index into the register list (byte address is 4 * index)
    localparam int unsigned REG_HALF_PERIOD = 0;
    localparam int unsigned REG_TIMEOUT     = 1;
    localparam int unsigned REG_ADDR_W      = 3;
    localparam int unsigned APB_DATA_W      = 32;

    localparam int unsigned HALF_W    = 16;
    localparam int unsigned TIMEOUT_W = 24;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned BITCNT_W  = 4;

    localparam logic [HALF_W-1:0]    HALF_PERIOD_RST = 16'd200;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 24'd7200000;

    localparam logic [BITCNT_W-1:0]  BITS_PER_BYTE   = 4'd8;

    // Command codes carried in the action field
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_STOP  = 2'd3;

    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;

    typedef struct packed {
        logic [HALF_W-1:0]    half_period;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ack_total;
        logic              timeout_flag;
        logic              ack_flag;
        logic              done_pulse;
        logic              busy_res;
        logic              sda_release;
        logic              scl_level;
    } res_t;

endpackage

`default_nettype wire

// ===== design/i2cmbw_regs.sv =====
`default_nettype none

module i2cmbw_regs
    import i2cmbw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [REG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [HALF_W-1:0]    half_period_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 wr_en;
    logic                 sel_timeout;

    assign pready      = 1'b1;
    assign wr_en       = psel && penable && pwrite;
    // Bits [1:0] of the address are ignored; bit 2 picks the register
    assign sel_timeout = (paddr[2] == REG_TIMEOUT[0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RST;
            timeout_reg     <= TIMEOUT_RST;
        end else if (wr_en) begin
            if (sel_timeout) begin
                timeout_reg <= pwdata[TIMEOUT_W-1:0];
            end else begin
                half_period_reg <= pwdata[HALF_W-1:0];
            end
        end
    end

    always_comb begin
        if (sel_timeout) begin
            prdata = {{(APB_DATA_W-TIMEOUT_W){1'b0}}, timeout_reg};
        end else begin
            prdata = {{(APB_DATA_W-HALF_W){1'b0}}, half_period_reg};
        end
    end

    assign cfg.half_period   = half_period_reg;
    assign cfg.timeout_ticks = timeout_reg;

endmodule

`default_nettype wire

// ===== design/i2cmbw_seq.sv =====
`default_nettype none

module i2cmbw_seq
    import i2cmbw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_fire,
    input  wire logic [1:0]        action,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              sda_in,
    input  wire cfg_t              cfg,
    output res_t                   res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_S1, PH_S2, PH_WLOW, PH_WHIGH, PH_WACKDLY, PH_WPOLL, PH_P1, PH_P2
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [BITCNT_W-1:0]   bit_left_reg, bit_left_next, bit_dec;
    logic [BYTE_W-1:0]     shift_reg, shift_next;
    logic [HALF_W-1:0]     wait_reg, wait_next;
    logic [TIMEOUT_W-1:0]  ack_wait_reg, ack_wait_next, ack_wait_inc;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  ack_seen_reg, ack_seen_next;
    logic                  timed_out_reg, timed_out_next;
    logic [BYTE_W-1:0]     ack_cnt_reg, ack_cnt_next;
    logic                  wait_last;
    logic                  done;

    // Delay counter ends on the tick it reads one or zero
    assign wait_last    = (wait_reg <= HALF_W'(1));
    assign bit_dec      = (bit_left_reg == '0) ? '0 : bit_left_reg - BITCNT_W'(1);
    assign ack_wait_inc = ack_wait_reg + TIMEOUT_W'(1);

    always_comb begin
        phase_next     = phase_reg;
        bit_left_next  = bit_left_reg;
        shift_next     = shift_reg;
        wait_next      = wait_reg;
        ack_wait_next  = ack_wait_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_seen_next  = ack_seen_reg;
        timed_out_next = timed_out_reg;
        ack_cnt_next   = ack_cnt_reg;
        done           = 1'b0;
        if (in_fire) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    unique case (action)
                        ACT_NONE: begin
                        end
                        ACT_START: begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            wait_next  = cfg.half_period;
                            phase_next = PH_S1;
                        end
                        ACT_WRITE: begin
                            shift_next    = data_byte;
                            bit_left_next = BITS_PER_BYTE;
                            scl_next      = 1'b0;
                            wait_next     = cfg.half_period;
                            phase_next    = PH_WLOW;
                        end
                        ACT_STOP: begin
                            sda_next   = 1'b0;
                            scl_next   = 1'b0;
                            phase_next = PH_P1;
                        end
                        default: begin
                        end
                    endcase
                end
                PH_S1: begin
                    wait_next = wait_last ? '0 : wait_reg - HALF_W'(1);
                    if (wait_last) begin
                        sda_next   = 1'b0;
                        wait_next  = cfg.half_period;
                        phase_next = PH_S2;
                    end
                end
                PH_S2: begin
                    wait_next = wait_last ? '0 : wait_reg - HALF_W'(1);
                    if (wait_last) begin
                        scl_next   = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_WLOW: begin
                    wait_next = wait_last ? '0 : wait_reg - HALF_W'(1);
                    if (wait_last) begin
                        sda_next   = shift_reg[BYTE_W-1];
                        shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        scl_next   = 1'b1;
                        wait_next  = cfg.half_period;
                        phase_next = PH_WHIGH;
                    end
                end
                PH_WHIGH: begin
                    wait_next = wait_last ? '0 : wait_reg - HALF_W'(1);
                    if (wait_last) begin
                        scl_next      = 1'b0;
                        bit_left_next = bit_dec;
                        wait_next     = cfg.half_period;
                        if (bit_dec != '0) begin
                            phase_next = PH_WLOW;
                        end else begin
                            // release SDA and raise SCL for the acknowledge slot
                            sda_next   = 1'b1;
                            scl_next   = 1'b1;
                            phase_next = PH_WACKDLY;
                        end
                    end
                end
                PH_WACKDLY: begin
                    wait_next = wait_last ? '0 : wait_reg - HALF_W'(1);
                    if (wait_last) begin
                        ack_wait_next = '0;
                        phase_next    = PH_WPOLL;
                    end
                end
                PH_WPOLL: begin
                    if (!sda_in) begin
                        ack_seen_next = 1'b1;
                        ack_cnt_next  = ack_cnt_reg + BYTE_W'(1);
                        scl_next      = 1'b0;
                        phase_next    = PH_IDLE;
                        done          = 1'b1;
                    end else begin
                        ack_wait_next = ack_wait_inc;
                        if (ack_wait_inc >= cfg.timeout_ticks) begin
                            timed_out_next = 1'b1;
                            scl_next       = 1'b0;
                            phase_next     = PH_IDLE;
                            done           = 1'b1;
                        end
                    end
                end
                PH_P1: begin
                    scl_next   = 1'b1;
                    wait_next  = cfg.half_period;
                    phase_next = PH_P2;
                end
                PH_P2: begin
                    wait_next = wait_last ? '0 : wait_reg - HALF_W'(1);
                    if (wait_last) begin
                        sda_next   = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_left_reg  <= '0;
            shift_reg     <= '0;
            wait_reg      <= '0;
            ack_wait_reg  <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_seen_reg  <= 1'b0;
            timed_out_reg <= 1'b0;
            ack_cnt_reg   <= '0;
        end else begin
            phase_reg     <= phase_next;
            bit_left_reg  <= bit_left_next;
            shift_reg     <= shift_next;
            wait_reg      <= wait_next;
            ack_wait_reg  <= ack_wait_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_seen_reg  <= ack_seen_next;
            timed_out_reg <= timed_out_next;
            ack_cnt_reg   <= ack_cnt_next;
        end
    end

    assign res.scl_level    = scl_next;
    assign res.sda_release  = sda_next;
    assign res.busy_res     = (phase_next != PH_IDLE);
    assign res.done_pulse   = done;
    assign res.ack_flag     = ack_seen_next;
    assign res.timeout_flag = timed_out_next;
    assign res.ack_total    = ack_cnt_next;

`ifndef ASSERT_OFF
    a_done_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && done |=> phase_reg == PH_IDLE)
        else $error("command finished but sequencer left idle");

    a_hold_without_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire |=> $stable(phase_reg) && $stable(wait_reg) && $stable(ack_cnt_reg))
        else $error("sequencer moved without an input beat");

    a_flags_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        timed_out_reg && ack_seen_reg |=> timed_out_reg && ack_seen_reg)
        else $error("sticky flag cleared");
`endif

endmodule

`default_nettype wire

// ===== design/i2cmbw_outbuf.sv =====
`default_nettype none

module i2cmbw_outbuf
    import i2cmbw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_fire,
    input  wire res_t res,
    output logic      in_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_res
);

    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign in_ready = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_res    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_free) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_fire) begin
            if (out_free) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_free) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (out_free) begin
                out_reg <= skid_reg;
            end
        end else if (in_fire) begin
            if (out_free) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output stage is empty");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && m_ready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid beat not moved to output stage");
`endif

endmodule

`default_nettype wire

// ===== design/i2c_master_byte_writer_unit.sv =====
`default_nettype none

// Channel   Dir  Ports                  Beat content (low bit first)
// s_axis    in   s_tvalid/tready/tdata  action[1:0], data_byte[9:2], sda_in[10]
// m_axis    out  m_tvalid/tready/tdata  scl_level, sda_release, busy_res,
//                                       done_pulse, ack_flag, timeout_flag,
//                                       ack_total[13:6]
// apb       in   psel..prdata           half_period @0x0, timeout_ticks @0x4
//
// Each input beat is one tick of the bus sequencer and yields one result beat,
// registered in the output stage; a beat is taken every cycle s_tready is high.
// The sequencer state registers feed a single output register plus a one-beat
// skid stage, so s_tready stays high while one result waits on m_tready.
// s_tready drops only once both the output and skid stages hold a beat.
// aresetn is synchronous, active low: lines released high, flags and ack
// count cleared, registers back to half_period 200 and timeout 7200000.
module i2c_master_byte_writer_unit
    import i2cmbw_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [REG_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [1:0] action, [9:2] data_byte, [10] sda_in, [15:11] zero
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] scl_level, [1] sda_release, [2] busy_res, [3] done_pulse,
    // [4] ack_flag, [5] timeout_flag, [13:6] ack_total, [15:14] zero
    output logic      [M_DATA_W-1:0]   m_tdata
);

    cfg_t cfg;
    res_t res;
    res_t m_res;
    logic in_fire;

    // Take a beat whenever the skid stage has room
    assign in_fire = s_tvalid && s_tready;

    i2cmbw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cmbw_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .action    (s_tdata[1:0]),
        .data_byte (s_tdata[9:2]),
        .sda_in    (s_tdata[10]),
        .cfg       (cfg),
        .res       (res)
    );

    i2cmbw_outbuf u_outbuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .res      (res),
        .in_ready (s_tready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    // Pack result fields, first field in the low bits, pad to whole bytes
    assign m_tdata = {2'b00, m_res.ack_total, m_res.timeout_flag, m_res.ack_flag,
                      m_res.done_pulse, m_res.busy_res, m_res.sda_release,
                      m_res.scl_level};

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import i2cmbw_pkg::*;

    localparam int CYCLE_LIMIT     = 100_000;
    localparam int ACK_NEVER       = -1;
    localparam int PHASE_BEATS     = 90;
    localparam int TRAFFIC_PHASES  = 6;

    // Bus sequencer phases of the predictor
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_START_HOLD,
        SEQ_START_LOW,
        SEQ_BIT_LOW,
        SEQ_BIT_HIGH,
        SEQ_ACK_SETTLE,
        SEQ_ACK_POLL,
        SEQ_STOP_LOW,
        SEQ_STOP_HIGH
    } seq_phase_e;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    // [1:0] action, [9:2] data_byte, [10] sda_in, [15:11] zero
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    // [0] scl_level, [1] sda_release, [2] busy_res, [3] done_pulse,
    // [4] ack_flag, [5] timeout_flag, [13:6] ack_total, [15:14] zero
    logic [M_DATA_W-1:0]   m_tdata;

    i2c_master_byte_writer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predicted line sequencer state, starting from its reset values
    cfg_t              cfg = '{half_period: HALF_PERIOD_RST, timeout_ticks: TIMEOUT_RST};
    seq_phase_e        bus_phase = SEQ_IDLE;
    logic [3:0]        bits_left = '0;
    logic [7:0]        tx_shift  = '0;
    logic [15:0]       dly_cnt   = '0;
    logic [23:0]       poll_cnt  = '0;
    logic              scl_q     = 1'b1;
    logic              sda_q     = 1'b1;
    logic              ack_seen  = 1'b0;
    logic              timed_out = 1'b0;
    logic [7:0]        ack_cnt   = '0;

    // Line states still owed by the block, oldest first
    res_t              line_q[$];

    bit                idle_on = 1'b1;
    int                mismatches = 0;
    int                rx_beats = 0;
    int                rx_hold = 0;
    int                cycle_cnt = 0;
    int                frame_pos = 0;
    int                frame_writes = 1;
    res_t              rx_got;
    res_t              rx_want;
    bit                rx_ok;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Count one delay tick; true on the last one (zero acts as one)
    function automatic bit delay_expired();
        if (dly_cnt <= 16'd1) begin
            dly_cnt = '0;
            return 1'b1;
        end
        dly_cnt = dly_cnt - 16'd1;
        return 1'b0;
    endfunction

    // Advance the sequencer by one tick and return the line state after it
    function automatic res_t predict_line_state(input logic [1:0] act, input logic [7:0] data,
                                                input logic sda_in);
        res_t r;
        logic done;
        done = 1'b0;
        case (bus_phase)
            SEQ_IDLE: begin
                if (act == ACT_START) begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    dly_cnt = cfg.half_period;
                    bus_phase = SEQ_START_HOLD;
                end else if (act == ACT_WRITE) begin
                    tx_shift = data;
                    bits_left = BITS_PER_BYTE;
                    scl_q = 1'b0;
                    dly_cnt = cfg.half_period;
                    bus_phase = SEQ_BIT_LOW;
                end else if (act == ACT_STOP) begin
                    sda_q = 1'b0;
                    scl_q = 1'b0;
                    bus_phase = SEQ_STOP_LOW;
                end
            end
            SEQ_START_HOLD: begin
                if (delay_expired()) begin
                    sda_q = 1'b0;
                    dly_cnt = cfg.half_period;
                    bus_phase = SEQ_START_LOW;
                end
            end
            SEQ_START_LOW: begin
                if (delay_expired()) begin
                    scl_q = 1'b0;
                    bus_phase = SEQ_IDLE;
                    done = 1'b1;
                end
            end
            SEQ_BIT_LOW: begin
                if (delay_expired()) begin
                    sda_q = tx_shift[7];
                    tx_shift = tx_shift << 1;
                    scl_q = 1'b1;
                    dly_cnt = cfg.half_period;
                    bus_phase = SEQ_BIT_HIGH;
                end
            end
            SEQ_BIT_HIGH: begin
                if (delay_expired()) begin
                    scl_q = 1'b0;
                    if (bits_left != '0)
                        bits_left = bits_left - 4'd1;
                    dly_cnt = cfg.half_period;
                    if (bits_left != '0) begin
                        bus_phase = SEQ_BIT_LOW;
                    end else begin
                        // release SDA and raise SCL for the acknowledge slot
                        sda_q = 1'b1;
                        scl_q = 1'b1;
                        bus_phase = SEQ_ACK_SETTLE;
                    end
                end
            end
            SEQ_ACK_SETTLE: begin
                if (delay_expired()) begin
                    poll_cnt = '0;
                    bus_phase = SEQ_ACK_POLL;
                end
            end
            SEQ_ACK_POLL: begin
                if (!sda_in) begin
                    ack_seen = 1'b1;
                    ack_cnt = ack_cnt + 8'd1;
                    scl_q = 1'b0;
                    bus_phase = SEQ_IDLE;
                    done = 1'b1;
                end else begin
                    poll_cnt = poll_cnt + 24'd1;
                    if (poll_cnt >= cfg.timeout_ticks) begin
                        timed_out = 1'b1;
                        scl_q = 1'b0;
                        bus_phase = SEQ_IDLE;
                        done = 1'b1;
                    end
                end
            end
            SEQ_STOP_LOW: begin
                scl_q = 1'b1;
                dly_cnt = cfg.half_period;
                bus_phase = SEQ_STOP_HIGH;
            end
            SEQ_STOP_HIGH: begin
                if (delay_expired()) begin
                    sda_q = 1'b1;
                    bus_phase = SEQ_IDLE;
                    done = 1'b1;
                end
            end
            default: bus_phase = SEQ_IDLE;
        endcase
        r.scl_level    = scl_q;
        r.sda_release  = sda_q;
        r.busy_res     = (bus_phase != SEQ_IDLE);
        r.done_pulse   = done;
        r.ack_flag     = ack_seen;
        r.timeout_flag = timed_out;
        r.ack_total    = ack_cnt;
        return r;
    endfunction

    // Push one tick beat into the block; predict its line state once accepted
    task automatic send_tick(input logic [1:0] act, input logic [7:0] data, input logic sda_in);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, sda_in, data, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        line_q.push_back(predict_line_state(act, data, sda_in));
    endtask

    // Issue one command and tick until the sequencer is idle again.
    // The slave acknowledges after ack_after high poll ticks, or never.
    task automatic run_cmd(input logic [1:0] act, input logic [7:0] data, input int ack_after,
                           input bit noisy);
        int polls;
        logic [1:0] busy_act;
        logic sda_in;
        polls = 0;
        send_tick(act, data, 1'b1);
        while (bus_phase != SEQ_IDLE) begin
            busy_act = noisy ? 2'($urandom_range(0, 3)) : ACT_NONE;
            sda_in = 1'b1;
            if (bus_phase == SEQ_ACK_POLL) begin
                sda_in = (ack_after != ACK_NEVER && polls >= ack_after) ? 1'b0 : 1'b1;
                polls++;
            end
            send_tick(busy_act, 8'($urandom_range(0, 255)), sda_in);
        end
    endtask

    task automatic apb_write(input int unsigned idx, input logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_HALF_PERIOD)
            cfg.half_period = value[HALF_W-1:0];
        else
            cfg.timeout_ticks = value[TIMEOUT_W-1:0];
    endtask

    // Finish any command in flight (acknowledge at once), let every line
    // state drain, then load both registers while the block sits idle
    task automatic set_timing(input logic [15:0] half, input logic [23:0] limit);
        while (bus_phase != SEQ_IDLE)
            send_tick(ACT_NONE, 8'h00, 1'b0);
        s_tvalid <= 1'b0;
        while (line_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        apb_write(REG_HALF_PERIOD, {16'b0, half});
        apb_write(REG_TIMEOUT, {8'b0, limit});
    endtask

    // Reset timing: a start condition paced by the default half period
    task automatic test_reset_defaults();
        run_cmd(ACT_START, 8'h00, 0, 1'b0);
    endtask

    task automatic test_start_stop();
        set_timing(16'd1, 24'd3);
        run_cmd(ACT_START, 8'h00, 0, 1'b0);
        run_cmd(ACT_STOP, 8'hFF, 0, 1'b0);
    endtask

    // Byte extremes, late acknowledge and a missing acknowledge
    task automatic test_write_ack();
        run_cmd(ACT_WRITE, 8'h00, 0, 1'b0);
        run_cmd(ACT_WRITE, 8'hFF, 2, 1'b0);
        run_cmd(ACT_WRITE, 8'hA5, ACK_NEVER, 1'b0);
        run_cmd(ACT_WRITE, 8'h5A, 3, 1'b0);
    endtask

    // Commands arriving mid-sequence must be dropped
    task automatic test_busy_ignored();
        run_cmd(ACT_START, 8'h00, 0, 1'b1);
        run_cmd(ACT_WRITE, 8'h3C, 1, 1'b1);
        run_cmd(ACT_STOP, 8'h00, 0, 1'b1);
    endtask

    // No action while idle leaves the lines alone
    task automatic test_idle_none();
        send_tick(ACT_NONE, 8'hFF, 1'b1);
        send_tick(ACT_NONE, 8'h00, 1'b0);
        send_tick(ACT_NONE, 8'hC3, 1'b1);
    endtask

    // Zero half period acts as one tick; zero timeout gives up on first high poll
    task automatic test_zero_settings();
        set_timing(16'd0, 24'd0);
        run_cmd(ACT_WRITE, 8'h81, ACK_NEVER, 1'b0);
        run_cmd(ACT_START, 8'h00, 0, 1'b0);
        run_cmd(ACT_WRITE, 8'h7E, 0, 1'b0);
        run_cmd(ACT_STOP, 8'h00, 0, 1'b0);
    endtask

    // Acknowledged writes back to back under the widest timeout
    task automatic test_ack_burst();
        set_timing(16'd0, 24'hFF_FFFF);
        repeat (10) run_cmd(ACT_WRITE, 8'($urandom_range(0, 255)), 0, 1'b0);
    endtask

    // Long half period: one stop condition holds one full delay
    task automatic test_long_half_period();
        set_timing(16'd60, 24'd2);
        run_cmd(ACT_STOP, 8'h00, 0, 1'b0);
    endtask

    // Mostly start / writes / stop frames with random bytes and acknowledge
    // timing, sprinkled with stray commands; last phase runs without idling
    task automatic test_random_traffic();
        logic [15:0] halves[TRAFFIC_PHASES];
        logic [23:0] limits[TRAFFIC_PHASES];
        int counted;
        logic [1:0] act;
        logic sda_in;
        halves = '{16'd1, 16'd2, 16'd0, 16'd3, 16'($urandom_range(1, 5)), 16'd1};
        limits = '{24'hFF_FFFF, 24'd1, 24'($urandom_range(2, 12)), 24'd0,
                   24'($urandom_range(1, 30)), 24'd4};
        for (int ph = 0; ph < TRAFFIC_PHASES; ph++) begin
            set_timing(halves[ph], limits[ph]);
            idle_on = (ph != TRAFFIC_PHASES - 1);
            counted = 0;
            while (counted < PHASE_BEATS) begin
                if (bus_phase != SEQ_IDLE) begin
                    act = 2'($urandom_range(0, 3));
                end else if ($urandom_range(0, 9) == 0) begin
                    act = 2'($urandom_range(0, 3));
                end else if (frame_pos == 0) begin
                    act = ACT_START;
                    frame_writes = $urandom_range(1, 3);
                    frame_pos = 1;
                end else if (frame_pos <= frame_writes) begin
                    act = ACT_WRITE;
                    frame_pos++;
                end else begin
                    act = ACT_STOP;
                    frame_pos = 0;
                end
                if (bus_phase == SEQ_ACK_POLL)
                    sda_in = ($urandom_range(0, 5) == 0) ? 1'b0 : 1'b1;
                else
                    sda_in = 1'($urandom_range(0, 1));
                if (bus_phase != SEQ_IDLE || act != ACT_NONE)
                    counted++;
                send_tick(act, 8'($urandom_range(0, 255)), sda_in);
            end
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_start_stop();
        test_write_ack();
        test_busy_ignored();
        test_idle_none();
        test_zero_settings();
        test_ack_burst();
        test_long_half_period();
        test_random_traffic();

        // Drop valid, wait for every owed line state, then a short tail
        s_tvalid <= 1'b0;
        while (line_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && line_q.size() == 0) begin
            $display("i2c_master_byte_writer_unit regression: pass");
        end else begin
            $display("i2c_master_byte_writer_unit regression: fail");
        end
        $finish;
    end

    // Result side back-pressure: random stall bursts
    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_hold  <= $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic bit field_ok(input string fname, input int want, input int got);
        if (want == got)
            return 1'b1;
        if (mismatches < 10)
            $display("beat %0d %s: expected %0d, got %0d", rx_beats, fname, want, got);
        return 1'b0;
    endfunction

    // Compare every accepted result beat against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (line_q.size() == 0) begin
                if (mismatches < 10)
                    $display("beat %0d: result with nothing expected", rx_beats);
                mismatches++;
            end else begin
                rx_want = line_q.pop_front();
                rx_ok = 1'b1;
                rx_ok = field_ok("scl_level", rx_want.scl_level, rx_got.scl_level) & rx_ok;
                rx_ok = field_ok("sda_release", rx_want.sda_release, rx_got.sda_release) & rx_ok;
                rx_ok = field_ok("busy_res", rx_want.busy_res, rx_got.busy_res) & rx_ok;
                rx_ok = field_ok("done_pulse", rx_want.done_pulse, rx_got.done_pulse) & rx_ok;
                rx_ok = field_ok("ack_flag", rx_want.ack_flag, rx_got.ack_flag) & rx_ok;
                rx_ok = field_ok("timeout_flag", rx_want.timeout_flag, rx_got.timeout_flag)
                        & rx_ok;
                rx_ok = field_ok("ack_total", rx_want.ack_total, rx_got.ack_total) & rx_ok;
                if (!rx_ok)
                    mismatches++;
            end
            rx_beats++;
        end
    end

    // Watchdog: give up well beyond the slowest legal run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("i2c_master_byte_writer_unit regression: fail");
            $finish;
        end
    end

endmodule

// ===== files.f =====
design/i2cmbw_pkg.sv
design/i2cmbw_regs.sv
design/i2cmbw_seq.sv
design/i2cmbw_outbuf.sv
design/i2c_master_byte_writer_unit.sv
verif/tb.sv
